// File: sv/assert_macros.svh
// Assertion helpers shared by the formatter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: sv/rdf_pkg.sv
`timescale 1ns / 1ps

package rdf_pkg;

    localparam int MAX_RADIX  = 16;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 64;
    localparam int MAX_DIGITS = 32;

    localparam logic [1:0] REG_SIZE = 2'd0;
    localparam logic [1:0] REG_LOW  = 2'd1;
    localparam logic [1:0] REG_HIGH = 2'd2;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DECIDE,
        ST_DIVIDE,
        ST_DIGIT,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic check_en;
        logic div_en;
        logic digit_store;
        logic emit;
        logic emit_bad;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic check_done;
        logic bad;
        logic bit_done;
        logic div_finish;
        logic emit_done;
    } status_t;

    function automatic logic [7:0] symbol_at(input logic [63:0] lo, input logic [63:0] hi,
                                             input logic [3:0] d);
        logic [127:0] all;
        all = {hi, lo};
        return all[{d, 3'b000} +: 8];
    endfunction

endpackage

// File: sv/rdf_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rdf_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  rdf_pkg::status_t status,
    output rdf_pkg::cmd_t    cmd,
    output logic             busy
);

    rdf_pkg::state_t state_reg;
    rdf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rdf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            rdf_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = rdf_pkg::ST_CHECK;
                end
            end
            rdf_pkg::ST_CHECK:
            begin
                cmd.check_en = 1'b1;
                if (status.check_done)
                begin
                    state_next = rdf_pkg::ST_DECIDE;
                end
            end
            rdf_pkg::ST_DECIDE:
            begin
                if (status.bad)
                begin
                    cmd.emit_bad = 1'b1;
                    state_next   = rdf_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = rdf_pkg::ST_DIVIDE;
                end
            end
            rdf_pkg::ST_DIVIDE:
            begin
                cmd.div_en = 1'b1;
                if (status.bit_done)
                begin
                    state_next = rdf_pkg::ST_DIGIT;
                end
            end
            rdf_pkg::ST_DIGIT:
            begin
                cmd.digit_store = 1'b1;
                state_next = status.div_finish ? rdf_pkg::ST_EMIT : rdf_pkg::ST_DIVIDE;
            end
            rdf_pkg::ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (status.emit_done)
                begin
                    state_next = rdf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rdf_pkg::ST_IDLE;
            end
        endcase
    end

    `ASSERT_IMPL(a_cmd_onehot, clk, rst_n, 1'b1, $onehot0(cmd))
    `ASSERT_NEXT(a_bad_ends_item, clk, rst_n, cmd.emit_bad, !busy)

endmodule

// File: sv/rdf_datapath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rdf_datapath
(
    input  logic             clk,
    input  logic             rst_n,
    input  rdf_pkg::cmd_t    cmd,
    output rdf_pkg::status_t status,
    input  logic [31:0]      number,
    input  logic [4:0]       alphabet_size,
    input  logic [63:0]      symbols_low,
    input  logic [63:0]      symbols_high,
    output logic             result_strobe,
    output logic [7:0]       symbol,
    output logic             last,
    output logic [5:0]       char_count,
    output logic             bad_alphabet
);

    logic [31:0] quot_reg;
    logic [3:0]  rem_reg;
    logic [4:0]  bit_cnt_reg;
    logic [3:0]  chk_idx_reg;
    logic        bad_reg;
    logic [5:0]  cnt_reg;
    logic [4:0]  emit_idx_reg;
    logic [3:0]  digit_mem [rdf_pkg::MAX_DIGITS];

    logic        strobe_reg;
    logic [7:0]  symbol_reg;
    logic        last_reg;
    logic [5:0]  char_count_reg;
    logic        bad_out_reg;

    // Symbol check: one symbol a cycle, for zero or sign bytes and against every later symbol in use.
    logic [7:0] chk_char;
    logic       chk_in_use;
    logic       chk_dup;
    logic       chk_fail;
    logic       size_bad;

    always_comb
    begin
        chk_char   = rdf_pkg::symbol_at(symbols_low, symbols_high, chk_idx_reg);
        chk_in_use = {1'b0, chk_idx_reg} < alphabet_size;
        chk_dup    = 1'b0;
        for (int j = 0; j < rdf_pkg::MAX_RADIX; j++)
        begin
            if (5'(j) > {1'b0, chk_idx_reg} && 5'(j) < alphabet_size &&
                rdf_pkg::symbol_at(symbols_low, symbols_high, 4'(j)) == chk_char)
            begin
                chk_dup = 1'b1;
            end
        end
        chk_fail = chk_in_use && (chk_char == 8'h00 || chk_char == rdf_pkg::CHAR_PLUS ||
                                  chk_char == rdf_pkg::CHAR_MINUS || chk_dup);
        size_bad = alphabet_size < 5'd2 || alphabet_size > 5'(rdf_pkg::MAX_RADIX);
    end

    // Restoring division, one quotient bit a cycle in the divide state.
    logic [4:0] trial;
    logic       trial_ge;
    logic [4:0] trial_diff;

    always_comb
    begin
        trial      = {rem_reg, quot_reg[31]};
        trial_ge   = trial >= alphabet_size;
        trial_diff = trial - alphabet_size;
    end

    always_comb
    begin
        status.check_done = chk_idx_reg == 4'(rdf_pkg::MAX_RADIX - 1);
        status.bad        = bad_reg || size_bad;
        status.bit_done   = bit_cnt_reg == 5'd31;
        status.div_finish = quot_reg == 32'd0 || cnt_reg == 6'(rdf_pkg::MAX_DIGITS - 1);
        status.emit_done  = emit_idx_reg == 5'd0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            quot_reg     <= number;
            rem_reg      <= 4'd0;
            bit_cnt_reg  <= 5'd0;
            chk_idx_reg  <= 4'd0;
            bad_reg      <= 1'b0;
            cnt_reg      <= 6'd0;
            emit_idx_reg <= 5'd0;
        end
        else
        begin
            if (cmd.check_en)
            begin
                chk_idx_reg <= chk_idx_reg + 4'd1;
                bad_reg     <= bad_reg | chk_fail;
            end
            if (cmd.div_en)
            begin
                quot_reg    <= {quot_reg[30:0], trial_ge};
                rem_reg     <= trial_ge ? trial_diff[3:0] : trial[3:0];
                bit_cnt_reg <= bit_cnt_reg + 5'd1;
            end
            if (cmd.digit_store)
            begin
                digit_mem[cnt_reg[4:0]] <= rem_reg;
                cnt_reg      <= cnt_reg + 6'd1;
                emit_idx_reg <= cnt_reg[4:0];
                rem_reg      <= 4'd0;
                bit_cnt_reg  <= 5'd0;
            end
            if (cmd.emit)
            begin
                emit_idx_reg <= emit_idx_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit || cmd.emit_bad;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_bad)
        begin
            symbol_reg     <= 8'h00;
            last_reg       <= 1'b1;
            char_count_reg <= 6'd0;
            bad_out_reg    <= 1'b1;
        end
        else if (cmd.emit)
        begin
            symbol_reg     <= rdf_pkg::symbol_at(symbols_low, symbols_high,
                                                 digit_mem[emit_idx_reg]);
            last_reg       <= emit_idx_reg == 5'd0;
            char_count_reg <= (emit_idx_reg == 5'd0) ? cnt_reg : 6'd0;
            bad_out_reg    <= 1'b0;
        end
    end

    assign result_strobe = strobe_reg;
    assign symbol        = symbol_reg;
    assign last          = last_reg;
    assign char_count    = char_count_reg;
    assign bad_alphabet  = bad_out_reg;

    `ASSERT_IMPL(a_bad_is_single, clk, rst_n, strobe_reg && bad_out_reg,
                 last_reg && char_count_reg == 6'd0)
    `ASSERT_IMPL(a_store_not_full, clk, rst_n, cmd.digit_store,
                 cnt_reg < 6'(rdf_pkg::MAX_DIGITS))
    `ASSERT_IMPL(a_rem_below_radix, clk, rst_n, cmd.digit_store,
                 {1'b0, rem_reg} < alphabet_size)

endmodule

// File: sv/radix_digit_formatter.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   | Handshake                          | Payload
// ----------+------------------------------------+----------------------------------------
// request   | start, busy (taken: start & !busy) | number
// result    | result_strobe (one cycle each)     | symbol, last, char_count, bad_alphabet
// config    | APB: psel, penable, pwrite, pready | paddr, pwdata, prdata (64-bit regs @ 8*i)
//
// A request passes through the alphabet check (one symbol per cycle) and a decision step,
// then the bit-serial divider for each digit, then one emitted digit per cycle through
// the output register.
// A bad alphabet gives its single result, registered from the decision state.
// Reset clears the controller, the output strobe and the configuration registers.
// Results cannot be stalled; busy stays high until the last one is issued.

module radix_digit_formatter
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [31:0]                  number,
    output logic                         result_strobe,
    output logic [7:0]                   symbol,
    output logic                         last,
    output logic [5:0]                   char_count,
    output logic                         bad_alphabet,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rdf_pkg::ADDR_W-1:0]   paddr,
    input  logic [rdf_pkg::DATA_W-1:0]   pwdata,
    output logic [rdf_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    logic [4:0]  alphabet_size_reg;
    logic [63:0] symbols_low_reg;
    logic [63:0] symbols_high_reg;
    logic [1:0]  reg_idx;
    logic        wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alphabet_size_reg <= 5'd0;
            symbols_low_reg   <= 64'd0;
            symbols_high_reg  <= 64'd0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                rdf_pkg::REG_SIZE: alphabet_size_reg <= pwdata[4:0];
                rdf_pkg::REG_LOW:  symbols_low_reg   <= pwdata;
                rdf_pkg::REG_HIGH: symbols_high_reg  <= pwdata;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            rdf_pkg::REG_SIZE: prdata = {59'd0, alphabet_size_reg};
            rdf_pkg::REG_LOW:  prdata = symbols_low_reg;
            rdf_pkg::REG_HIGH: prdata = symbols_high_reg;
            default:           prdata = '0;
        endcase
    end

    rdf_pkg::cmd_t    cmd;
    rdf_pkg::status_t status;

    rdf_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    rdf_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .number        (number),
        .alphabet_size (alphabet_size_reg),
        .symbols_low   (symbols_low_reg),
        .symbols_high  (symbols_high_reg),
        .result_strobe (result_strobe),
        .symbol        (symbol),
        .last          (last),
        .char_count    (char_count),
        .bad_alphabet  (bad_alphabet)
    );

    // A fresh request starts with the alphabet check, so no result follows it at once.
    `ASSERT_NEXT(a_no_result_after_start, clk, rst_n, start && !busy, !result_strobe)

endmodule

// File: tb/sv/digit_stream_checker.sv
`timescale 1ns / 1ps

module digit_stream_checker
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic [31:0]                number,
    input  logic                       result_strobe,
    input  logic [7:0]                 symbol,
    input  logic                       last,
    input  logic [5:0]                 char_count,
    input  logic                       bad_alphabet,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       pready,
    input  logic [rdf_pkg::ADDR_W-1:0] paddr,
    input  logic [rdf_pkg::DATA_W-1:0] pwdata,
    output int                         mismatches,
    output int                         outstanding
);

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
        logic [5:0] total;
        logic       bad;
    } char_t;

    logic [4:0]  radix_reg;
    logic [63:0] low_reg;
    logic [63:0] high_reg;
    char_t       due_chars[$];
    char_t       head;
    int          fault_total = 0;

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        fault_total++;
    endtask

    function automatic logic [7:0] glyph(input int d);
        logic [127:0] bank;
        bank = {high_reg, low_reg};
        return bank[d*8 +: 8];
    endfunction

    // An alphabet is usable when its size is 2 to 16 and every symbol in use is nonzero,
    // is no sign character, and appears only once; bytes past the size do not matter.
    function automatic bit alphabet_usable();
        logic [7:0] c;
        if (radix_reg < 2 || radix_reg > rdf_pkg::MAX_RADIX)
            return 1'b0;
        for (int i = 0; i < radix_reg; i++)
        begin
            c = glyph(i);
            if (c == 8'h00 || c == rdf_pkg::CHAR_PLUS || c == rdf_pkg::CHAR_MINUS)
                return 1'b0;
            for (int j = i + 1; j < radix_reg; j++)
                if (glyph(j) == c)
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void spell_number(input logic [31:0] value);
        logic [7:0]  digits[32];
        logic [31:0] rest;
        int          n;
        if (!alphabet_usable())
        begin
            due_chars.push_back('{ch: 8'h00, fin: 1'b1, total: 6'd0, bad: 1'b1});
            return;
        end
        rest = value;
        n = 0;
        // The first pass always runs, so zero spells as the symbol for digit 0.
        do
        begin
            digits[n] = glyph(int'(rest % radix_reg));
            rest = rest / radix_reg;
            n++;
        end
        while (rest != 0 && n < 32);
        for (int k = n - 1; k >= 0; k--)
            due_chars.push_back('{ch: digits[k], fin: (k == 0),
                                  total: (k == 0) ? 6'(n) : 6'd0, bad: 1'b0});
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg = '0;
            low_reg   = '0;
            high_reg  = '0;
            due_chars.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[2:0] == 3'b000)
            begin
                unique case (paddr[rdf_pkg::ADDR_W-1:3])
                    rdf_pkg::REG_SIZE: radix_reg = pwdata[4:0];
                    rdf_pkg::REG_LOW:  low_reg   = pwdata;
                    rdf_pkg::REG_HIGH: high_reg  = pwdata;
                    default:           ;
                endcase
            end
            if (result_strobe)
            begin
                if (due_chars.size() == 0)
                    report_mismatch($sformatf("result %h with no request pending", symbol));
                else
                begin
                    head = due_chars.pop_front();
                    if (symbol !== head.ch)
                        report_mismatch($sformatf("symbol %h, want %h", symbol, head.ch));
                    if (last !== head.fin)
                        report_mismatch($sformatf("last %b, want %b", last, head.fin));
                    if (char_count !== head.total)
                        report_mismatch($sformatf("char_count %0d, want %0d",
                                                  char_count, head.total));
                    if (bad_alphabet !== head.bad)
                        report_mismatch($sformatf("bad_alphabet %b, want %b",
                                                  bad_alphabet, head.bad));
                end
            end
            if (start && !busy)
                spell_number(number);
        end
        outstanding <= due_chars.size();
        mismatches  <= fault_total;
    end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int STALL_LIMIT = 6000;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [31:0]                  number;
    logic                         result_strobe;
    logic [7:0]                   symbol;
    logic                         last;
    logic [5:0]                   char_count;
    logic                         bad_alphabet;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [rdf_pkg::ADDR_W-1:0]   paddr;
    logic [rdf_pkg::DATA_W-1:0]   pwdata;
    logic [rdf_pkg::DATA_W-1:0]   prdata;
    logic                         pready;

    int                  mismatches;
    int                  outstanding;
    int                  stall_cycles = 0;
    int                  sent = 0;
    logic [4:0]          cur_radix = '0;
    logic [4:0]          next_size;
    logic [63:0]         next_low;
    logic [63:0]         next_high;
    bit                  burst;
    int                  batch;

    radix_digit_formatter u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .number        (number),
        .result_strobe (result_strobe),
        .symbol        (symbol),
        .last          (last),
        .char_count    (char_count),
        .bad_alphabet  (bad_alphabet),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    digit_stream_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .number        (number),
        .result_strobe (result_strobe),
        .symbol        (symbol),
        .last          (last),
        .char_count    (char_count),
        .bad_alphabet  (bad_alphabet),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || result_strobe || (psel && penable))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [31:0] pick_number(input logic [4:0] radix);
        logic [63:0] p;
        unique case ($urandom_range(0, 9))
            0, 1, 2: return $urandom;
            3:       return 32'd0;
            4:       return 32'hFFFF_FFFF;
            5:       return 32'($urandom_range(0, 40));
            6:       return $urandom >> $urandom_range(0, 31);
            7:       return 32'd1 << $urandom_range(0, 31);
            default:
            begin
                // Land on or just below a power of the radix.
                if (radix < 2)
                    return $urandom;
                p = 64'd1;
                repeat ($urandom_range(1, 31))
                    if (p * radix <= 64'hFFFF_FFFF)
                        p = p * radix;
                return 32'(p - $urandom_range(0, 1));
            end
        endcase
    endfunction

    task automatic send_number(input logic [31:0] value, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start  <= 1'b1;
        number <= value;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
    endtask

    task automatic drain(input int tail);
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 || busy)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    // Leaves psel high for a following write; the caller drops it.
    task automatic write_reg(input logic [1:0] index, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
    endtask

    task automatic load_alphabet(input logic [4:0] size, input logic [63:0] lo,
                                 input logic [63:0] hi);
        logic [63:0] size_word;
        drain(4);
        // Upper bits of the size word carry noise that the block must drop.
        size_word = {$urandom, $urandom};
        size_word[4:0] = size;
        write_reg(rdf_pkg::REG_SIZE, size_word);
        write_reg(rdf_pkg::REG_LOW, lo);
        write_reg(rdf_pkg::REG_HIGH, hi);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        cur_radix = size;
    endtask

    task automatic make_random_alphabet(output logic [4:0] size, output logic [63:0] lo,
                                        output logic [63:0] hi);
        logic [7:0] sym[16];
        bit         taken[256];
        logic [7:0] c;
        int         a;
        int         b;
        a = $urandom_range(0, 5);
        size = (a == 0) ? 5'd2 : (a == 1) ? 5'd16 : 5'($urandom_range(2, 16));
        foreach (taken[i])
            taken[i] = 1'b0;
        taken[0] = 1'b1;
        taken[rdf_pkg::CHAR_PLUS] = 1'b1;
        taken[rdf_pkg::CHAR_MINUS] = 1'b1;
        for (int i = 0; i < 16; i++)
        begin
            if (i < size)
            begin
                do c = 8'($urandom); while (taken[c]);
                taken[c] = 1'b1;
                sym[i] = c;
            end
            else
                sym[i] = 8'($urandom);
        end
        // About one alphabet in five is spoiled in a single way.
        if ($urandom_range(0, 4) == 0)
        begin
            a = $urandom_range(0, size - 1);
            unique case ($urandom_range(0, 4))
                0:
                begin
                    if ($urandom_range(0, 1) == 1)
                        size = 5'($urandom_range(17, 31));
                    else
                        size = 5'($urandom_range(0, 1));
                end
                1: sym[a] = rdf_pkg::CHAR_PLUS;
                2: sym[a] = rdf_pkg::CHAR_MINUS;
                3: sym[a] = 8'h00;
                default:
                begin
                    b = $urandom_range(0, size - 1);
                    if (b == a)
                        b = (a + 1) % size;
                    sym[b] = sym[a];
                end
            endcase
        end
        for (int i = 0; i < 8; i++)
        begin
            lo[i*8 +: 8] = sym[i];
            hi[i*8 +: 8] = sym[i + 8];
        end
    endtask

    initial
    begin
        rst_n   <= 1'b0;
        start   <= 1'b0;
        number  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The alphabet after reset is empty, so every request is refused.
        send_number(32'd0, pick_gap());
        send_number(32'hFFFF_FFFF, 0);

        // Binary, with signs, a zero and repeats in the unused bytes.
        load_alphabet(5'd2, 64'h31302D2B_00313130, '1);
        send_number(32'd0, pick_gap());
        send_number(32'd1, 0);
        send_number(32'hFFFF_FFFF, pick_gap());
        send_number(32'h8000_0000, 0);
        send_number(32'h5555_5555, pick_gap());

        // Full sixteen-symbol alphabet.
        load_alphabet(5'd16, 64'h37363534_33323130, 64'h66656463_62613938);
        send_number(32'd0, pick_gap());
        send_number(32'hFFFF_FFFF, 0);
        send_number(32'h0000_000F, pick_gap());
        send_number(32'h0000_0010, 0);
        send_number(32'h1234_5678, pick_gap());

        // Decimal, with junk past the tenth symbol.
        load_alphabet(5'd10, 64'h37363534_33323130, 64'h2B2D0000_30313938);
        send_number(32'hFFFF_FFFF, pick_gap());
        send_number(32'd1000000000, 0);
        send_number(32'd999999999, pick_gap());
        send_number(32'd7, 0);

        // Alphabets that must be refused.
        load_alphabet(5'd1, 64'h37363534_33323130, 64'h66656463_62613938);
        send_number(32'd5, pick_gap());
        load_alphabet(5'd17, 64'h37363534_33323130, 64'h66656463_62613938);
        send_number(32'd5, pick_gap());
        load_alphabet(5'd31, 64'h37363534_33323130, 64'h66656463_62613938);
        send_number(32'd5, pick_gap());
        load_alphabet(5'd4, 64'h00000000_332B3130, '0);
        send_number(32'd5, pick_gap());
        load_alphabet(5'd12, 64'h37363534_33323130, 64'h66656463_2D613938);
        send_number(32'd5, pick_gap());
        load_alphabet(5'd8, 64'h00363534_33323130, '1);
        send_number(32'd5, pick_gap());
        load_alphabet(5'd16, 64'h37363534_33323130, 64'h30656463_62613938);
        send_number(32'd5, pick_gap());

        while (sent < 480)
        begin
            make_random_alphabet(next_size, next_low, next_high);
            load_alphabet(next_size, next_low, next_high);
            burst = ($urandom_range(0, 4) == 0);
            batch = $urandom_range(4, 16);
            for (int i = 0; i < batch; i++)
                send_number(pick_number(cur_radix), burst ? 0 : pick_gap());
        end

        drain(40);
        if (mismatches == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
